@@ design/cps_pkg.sv @@
// Shared codes, widths and types for the circular predecessor search block.
`default_nettype none
package cps_pkg;

	localparam int unsigned FUNC_W = 2;
	localparam int unsigned VAL_W  = 32;
	localparam int unsigned IDX_W  = 9;

	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST
	} scan_state_t;

	typedef struct packed {
		logic                    valid;
		logic                    found;
		logic [IDX_W-1:0]        index;
		logic signed [VAL_W-1:0] value;
		logic                    batch_end;
	} res_t;

endpackage
`default_nettype wire

@@ design/cps_mem.sv @@
// Entry store: one write port, one read port with registered read data.
`default_nettype none
module cps_mem
	import cps_pkg::*;
#(
	parameter int unsigned DEPTH  = 512,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [VAL_W-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [VAL_W-1:0]  rd_data
);

	logic [VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ design/cps_scan.sv @@
// Query sequencer: sweeps the stored entries and keeps the running maximum and predecessor.
`default_nettype none
module cps_scan
	import cps_pkg::*;
#(
	parameter int unsigned DEPTH  = 512,
	parameter int unsigned ADDR_W = $clog2(DEPTH),
	parameter int unsigned CNT_W  = $clog2(DEPTH + 1)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    go,
	input  wire logic signed [VAL_W-1:0] q,
	input  wire logic                    last,
	input  wire logic [CNT_W-1:0]        count,
	input  wire logic [VAL_W-1:0]        rd_data,
	output logic                         busy,
	output logic                         rd_en,
	output logic [ADDR_W-1:0]            rd_addr,
	output res_t                         res
);

	scan_state_t state_q, state_d;

	logic signed [VAL_W-1:0] q_q;
	logic                    last_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [ADDR_W-1:0]       ptr_q;
	logic                    vld_s1;
	logic [ADDR_W-1:0]       idx_s1;

	logic signed [VAL_W-1:0] max_q, best_q;
	logic [ADDR_W-1:0]       max_pos_q, best_pos_q;
	logic                    have_q;

	logic signed [VAL_W-1:0] v;
	logic signed [VAL_W-1:0] max_d, best_d;
	logic [ADDR_W-1:0]       max_pos_d, best_pos_d;
	logic                    have_d;
	logic                    take_max, take_best;
	logic [31:0]             pos_ext;
	logic                    empty_go;

	assign empty_go = go && (count == '0);

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = ptr_q;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (go && (count != '0)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (CNT_W'(ptr_q) == cnt_q - CNT_W'(1)) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && go) begin
			q_q    <= q;
			last_q <= last;
			cnt_q  <= count;
			ptr_q  <= '0;
		end else if (rd_en) begin
			ptr_q <= ptr_q + ADDR_W'(1);
		end
		idx_s1 <= ptr_q;
	end

	// running maximum and predecessor; the first word seeds the maximum
	always_comb begin
		v         = signed'(rd_data);
		take_max  = (idx_s1 == '0) || (v > max_q);
		take_best = (v < q_q) && (!have_q || (v > best_q));
		max_d      = take_max ? v : max_q;
		max_pos_d  = take_max ? idx_s1 : max_pos_q;
		best_d     = take_best ? v : best_q;
		best_pos_d = take_best ? idx_s1 : best_pos_q;
		have_d     = have_q || take_best;
		pos_ext    = have_d ? 32'(best_pos_d) : 32'(max_pos_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (state_q == ST_IDLE) begin
			have_q <= 1'b0;
		end else if (vld_s1) begin
			have_q <= have_d;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			max_q      <= max_d;
			max_pos_q  <= max_pos_d;
			best_q     <= best_d;
			best_pos_q <= best_pos_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res <= '0;
		end else begin
			res.valid <= (state_q == ST_LAST) || (state_q == ST_IDLE && empty_go);
			if (state_q == ST_LAST) begin
				res.found     <= 1'b1;
				res.index     <= pos_ext[IDX_W-1:0];
				res.value     <= have_d ? best_d : max_d;
				res.batch_end <= last_q;
			end else if (state_q == ST_IDLE && empty_go) begin
				res.found     <= 1'b0;
				res.index     <= '0;
				res.value     <= '0;
				res.batch_end <= last;
			end
		end
	end

	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (CNT_W'(rd_addr) < cnt_q))
		else $error("read address beyond stored entries");

	a_data_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (CNT_W'(idx_s1) < cnt_q))
		else $error("read word tagged with position beyond stored entries");

	a_found_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.found) |-> $past(state_q == ST_LAST))
		else $error("found result without a completed scan");

	a_last_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LAST) |-> vld_s1)
		else $error("final scan cycle without read data");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.found) |-> (res.value == '0 && res.index == '0))
		else $error("empty-table result not zeroed");

endmodule
`default_nettype wire

@@ design/circular_predecessor_search.sv @@
// Top level: command decode, entry count, entry store and query sequencer.
`default_nettype none
// Holds up to DEPTH signed 32-bit entries in insertion order. A word is taken
// when start is high and busy is low. Clear and append give no result; an
// append to a full table is dropped. A query reads the stored entries one per
// cycle through the single read port of the entry store, keeps busy high while
// it sweeps them and shows its result in the first cycle that busy is low again,
// marked by done for exactly one cycle; a query on an empty table gives found 0
// in the next cycle without raising busy. The target is the largest entry
// below the query value, or the largest entry when none is below; equal values
// resolve to the earliest position. Results cannot be held off, so capture them
// when done is high.
module circular_predecessor_search
	import cps_pkg::*;
#(
	parameter int unsigned DEPTH = 512
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [FUNC_W-1:0]       func,
	input  wire logic signed [VAL_W-1:0] item_value,
	input  wire logic                    last_query,
	output logic                         done,
	output logic                         found,
	output logic [IDX_W-1:0]             target_index,
	output logic signed [VAL_W-1:0]      target_value,
	output logic                         batch_end
);

	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

	logic              accept;
	logic              do_clear, do_append, do_query;
	logic [CNT_W-1:0]  count_q;
	logic              not_full;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [VAL_W-1:0]  rd_data;
	res_t              res;

	assign accept   = start && !busy;
	assign not_full = count_q < CNT_W'(DEPTH);

	always_comb begin
		do_clear  = 1'b0;
		do_append = 1'b0;
		do_query  = 1'b0;
		unique case (func)
			FUNC_CLEAR:  do_clear  = accept;
			FUNC_APPEND: do_append = accept && not_full;
			FUNC_QUERY:  do_query  = accept;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_clear) begin
			count_q <= '0;
		end else if (do_append) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	cps_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (do_append),
		.wr_addr (count_q[ADDR_W-1:0]),
		.wr_data (item_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	cps_scan #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W),
		.CNT_W  (CNT_W)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (do_query),
		.q       (item_value),
		.last    (last_query),
		.count   (count_q),
		.rd_data (rd_data),
		.busy    (busy),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.res     (res)
	);

	assign done         = res.valid;
	assign found        = res.found;
	assign target_index = res.index;
	assign target_value = res.value;
	assign batch_end    = res.batch_end;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above table depth");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !do_append)
		else $error("append overlaps a query sweep");

	a_count_stable_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && $past(busy)) |-> $stable(count_q))
		else $error("entry count moved during a query");

endmodule
`default_nettype wire

@@ test/cps_result_checker.sv @@
// Checker: mirrors the entry table, predicts each lookup result and compares it.
module cps_result_checker
	import cps_pkg::*;
#(
	parameter int unsigned DEPTH = 512
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic                    busy,
	input  wire logic [FUNC_W-1:0]       func,
	input  wire logic signed [VAL_W-1:0] item_value,
	input  wire logic                    last_query,
	input  wire logic                    done,
	input  wire logic                    found,
	input  wire logic [IDX_W-1:0]        target_index,
	input  wire logic signed [VAL_W-1:0] target_value,
	input  wire logic                    batch_end,
	output int                           fail_count,
	output int                           pending,
	output int                           checked
);

	logic signed [VAL_W-1:0] entry_mem [DEPTH];
	int unsigned             n_entries;
	res_t                    lookup_q [$];
	res_t                    want;

	// largest entry below the key; the largest entry when nothing lies below,
	// when the key is outside the stored range or equals the smallest entry
	function automatic res_t lookup_target(input logic signed [VAL_W-1:0] key,
			input logic lq);
		res_t                    r;
		int unsigned             i;
		int unsigned             hi_pos;
		int unsigned             best_pos;
		int unsigned             pos;
		logic signed [VAL_W-1:0] hi_v;
		logic signed [VAL_W-1:0] lo_v;
		logic signed [VAL_W-1:0] best_v;
		logic signed [VAL_W-1:0] v;
		bit                      have_best;
		r = '0;
		r.valid = 1'b1;
		r.batch_end = lq;
		if (n_entries == 0)
			return r;
		hi_pos = 0;
		best_pos = 0;
		have_best = 1'b0;
		hi_v = entry_mem[0];
		lo_v = hi_v;
		best_v = '0;
		for (i = 0; i < n_entries; i++) begin
			v = entry_mem[i];
			if (v > hi_v) begin
				hi_v = v;
				hi_pos = i;
			end
			if (v < lo_v)
				lo_v = v;
			// strict compares keep the earliest position on ties
			if (v < key && (!have_best || v > best_v)) begin
				best_v = v;
				best_pos = i;
				have_best = 1'b1;
			end
		end
		if (key < lo_v || key > hi_v || !have_best)
			pos = hi_pos;
		else
			pos = best_pos;
		r.found = 1'b1;
		r.index = pos[IDX_W-1:0];
		r.value = entry_mem[pos];
		return r;
	endfunction

	task automatic report(input string what, input logic signed [VAL_W:0] exp_v,
			input logic signed [VAL_W:0] got_v);
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookup_q.delete();
			n_entries = 0;
			pending = 0;
			checked = 0;
			fail_count = 0;
		end else begin
			// retire first: a result never belongs to a word taken on the same edge
			if (done) begin
				if (lookup_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, got index %0d value %0d",
						$time, target_index, target_value);
					fail_count++;
				end else begin
					want = lookup_q.pop_front();
					checked++;
					if (found !== want.found)
						report("found", want.found, found);
					if (target_index !== want.index)
						report("target_index", want.index, target_index);
					if (target_value !== want.value)
						report("target_value", want.value, target_value);
					if (batch_end !== want.batch_end)
						report("batch_end", want.batch_end, batch_end);
				end
			end
			if (start && !busy) begin
				case (func)
					FUNC_CLEAR: begin
						n_entries = 0;
					end
					FUNC_APPEND: begin
						if (n_entries < DEPTH) begin
							entry_mem[n_entries] = item_value;
							n_entries++;
						end
					end
					FUNC_QUERY: begin
						lookup_q.push_back(lookup_target(item_value, last_query));
					end
					default: ;
				endcase
			end
			pending = lookup_q.size();
		end
	end

endmodule

@@ test/tb_circular_predecessor_search.sv @@
// Testbench top: clock, reset, word stimulus, watchdog and verdict.
module tb_circular_predecessor_search;
	import cps_pkg::*;

	localparam int unsigned DEPTH       = 512;
	localparam int          N_WORDS     = 1170;
	localparam int          CALM_AFTER  = 1050;
	localparam int          WATCH_LIMIT = 4000;
	localparam int          SETTLE      = 16;

	localparam logic [FUNC_W-1:0]       FUNC_UNUSED = 2'd3;
	localparam logic signed [VAL_W-1:0] MIN_VAL     = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] MAX_VAL     = 32'sh7fff_ffff;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic [FUNC_W-1:0]       func;
	logic signed [VAL_W-1:0] item_value;
	logic                    last_query;
	logic                    busy;
	logic                    done;
	logic                    found;
	logic [IDX_W-1:0]        target_index;
	logic signed [VAL_W-1:0] target_value;
	logic                    batch_end;

	int fail_count;
	int pending;
	int checked;
	int quiet;
	int n_words;
	int n_batches;

	// values held by the block, used to aim lookup keys and to decide on clears
	logic signed [VAL_W-1:0] stored [$];

	circular_predecessor_search #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.item_value(item_value),
		.last_query(last_query),
		.done(done),
		.found(found),
		.target_index(target_index),
		.target_value(target_value),
		.batch_end(batch_end)
	);

	cps_result_checker #(
		.DEPTH(DEPTH)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.item_value(item_value),
		.last_query(last_query),
		.done(done),
		.found(found),
		.target_index(target_index),
		.target_value(target_value),
		.batch_end(batch_end),
		.fail_count(fail_count),
		.pending(pending),
		.checked(checked)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= WATCH_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, WATCH_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic send_word(input logic [FUNC_W-1:0] f, input logic signed [VAL_W-1:0] v,
			input logic lq);
		int gap;
		gap = 0;
		if (n_words < CALM_AFTER && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 17);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		func <= f;
		item_value <= v;
		last_query <= lq;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		case (f)
			FUNC_CLEAR: begin
				stored.delete();
				n_words++;
			end
			FUNC_APPEND: begin
				if (stored.size() < DEPTH) begin
					stored.push_back(v);
					n_words++;
				end
			end
			FUNC_QUERY: begin
				n_words++;
			end
			default: ;
		endcase
	endtask

	// hold the next word back until every lookup has answered
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	function automatic logic signed [VAL_W-1:0] entry_value(input int style);
		logic signed [VAL_W-1:0] v;
		v = $urandom;
		case (style)
			0: ;
			1: begin
				// narrow range: plenty of equal entries
				v = $urandom_range(0, 8);
				v = v - 4;
			end
			default: begin
				case ($urandom_range(0, 3))
					0: v = MIN_VAL;
					1: v = MAX_VAL;
					2: begin
						v = $urandom_range(0, 4);
						v = v - 2;
					end
					default: ;
				endcase
			end
		endcase
		return v;
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_key();
		logic signed [VAL_W-1:0] k;
		int                      i;
		k = $urandom;
		if (stored.size() != 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2: k = stored[$urandom_range(0, stored.size() - 1)];
				3: k = stored[$urandom_range(0, stored.size() - 1)] + 1;
				4: k = stored[$urandom_range(0, stored.size() - 1)] - 1;
				5: k = MIN_VAL;
				6: k = MAX_VAL;
				7: begin
					k = $urandom_range(0, 16);
					k = k - 8;
				end
				8: begin
					k = stored[0];
					for (i = 1; i < stored.size(); i++)
						if (stored[i] < k)
							k = stored[i];
				end
				default: ;
			endcase
		end
		return k;
	endfunction

	initial begin
		int                i;
		int                n;
		int                k;
		int                style;
		logic [FUNC_W-1:0] f;
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_CLEAR;
		item_value = '0;
		last_query = 1'b0;
		n_words = 0;
		n_batches = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, unused code, ties, extremes, key equal to the smallest entry
		send_word(FUNC_QUERY, 32'sd7, 1'b1);
		send_word(FUNC_UNUSED, '1, 1'b1);
		send_word(FUNC_APPEND, 32'sd5, 1'b0);
		send_word(FUNC_APPEND, -32'sd3, 1'b1);
		send_word(FUNC_APPEND, 32'sd5, 1'b0);
		send_word(FUNC_APPEND, MIN_VAL, 1'b0);
		send_word(FUNC_APPEND, MAX_VAL, 1'b1);
		send_word(FUNC_APPEND, MIN_VAL, 1'b0);
		send_word(FUNC_QUERY, 32'sd5, 1'b0);
		send_word(FUNC_QUERY, MIN_VAL, 1'b0);
		send_word(FUNC_QUERY, 32'sd6, 1'b0);
		send_word(FUNC_QUERY, MAX_VAL, 1'b0);
		send_word(FUNC_QUERY, -32'sd3, 1'b1);
		send_word(FUNC_CLEAR, '1, 1'b1);
		send_word(FUNC_APPEND, 32'sd10, 1'b0);
		send_word(FUNC_APPEND, 32'sd20, 1'b0);
		send_word(FUNC_QUERY, 32'sd30, 1'b0);
		send_word(FUNC_QUERY, 32'sd10, 1'b0);
		send_word(FUNC_QUERY, 32'sd15, 1'b0);
		send_word(FUNC_QUERY, -32'sd100, 1'b1);
		send_word(FUNC_UNUSED, 32'sd0, 1'b0);

		while (n_words < N_WORDS) begin
			n_batches++;
			if (n_batches == 3) begin
				// fill to the brim, largest entry last, then overflow appends
				send_word(FUNC_CLEAR, $urandom, 1'b0);
				for (i = 0; i < DEPTH - 1; i++)
					send_word(FUNC_APPEND, entry_value(0), 1'($urandom_range(0, 1)));
				send_word(FUNC_APPEND, MAX_VAL, 1'b0);
				repeat (3)
					send_word(FUNC_APPEND, entry_value(2), 1'b1);
				for (i = 1; i <= 6; i++)
					send_word(FUNC_QUERY, pick_key(), i == 6);
				drain();
			end else begin
				case ($urandom_range(0, 9))
					7: begin
						n = $urandom_range(1, 8);
						repeat (n) begin
							f = FUNC_W'($urandom_range(0, 3));
							send_word(f, $urandom, 1'($urandom_range(0, 1)));
						end
					end
					8: begin
						case ($urandom_range(0, 2))
							0: begin
								send_word(FUNC_CLEAR, $urandom, 1'b0);
								n = $urandom_range(1, 3);
								repeat (n)
									send_word(FUNC_QUERY, $urandom,
										1'($urandom_range(0, 1)));
							end
							1: begin
								n = $urandom_range(1, 6);
								repeat (n)
									send_word(FUNC_APPEND, entry_value(2), 1'b0);
								send_word(FUNC_CLEAR, $urandom, 1'b1);
							end
							default: begin
								n = $urandom_range(1, 4);
								repeat (n) begin
									send_word(FUNC_APPEND, entry_value(1), 1'b0);
									send_word(FUNC_QUERY, pick_key(), 1'b0);
								end
							end
						endcase
					end
					9: begin
						drain();
						send_word(FUNC_QUERY, pick_key(), 1'b1);
					end
					default: begin
						if (stored.size() > 100 || $urandom_range(0, 4) != 0)
							send_word(FUNC_CLEAR, $urandom, 1'b0);
						style = $urandom_range(0, 2);
						if ($urandom_range(0, 9) == 0)
							n = $urandom_range(17, 60);
						else
							n = $urandom_range(1, 16);
						repeat (n)
							send_word(FUNC_APPEND, entry_value(style),
								1'($urandom_range(0, 1)));
						k = $urandom_range(1, 6);
						for (i = 1; i <= k; i++)
							send_word(FUNC_QUERY, pick_key(), i == k);
					end
				endcase
			end
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		$display("Sent %0d words in %0d batches, one full-table fill with overflow included",
			n_words, n_batches);
		$display("Checked %0d lookup results, %0d mismatches", checked, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
